/* sv/sfir_pkg.sv */
`timescale 1ns / 1ps

package sfir_pkg;

   // Longest supported kernel half length; the coefficient index and the
   // half_length register are sized for it.
   localparam int MAX_HALF = 12;

   // Fixed field widths of the stream and register port.
   localparam int SAMPLE_MAX_BITS = 24;
   localparam int COEF_BITS       = 18;
   localparam int FRAC_BITS       = 16;
   localparam int COEF_INDEX_BITS = 4;
   localparam int HALF_BITS       = 4;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 4;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_LENGTH    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYMMETRIC_MODE = 4'd1;

   typedef enum logic {
      ITEM_PIXEL,
      ITEM_COEF
   } item_kind_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      item_kind_type                      kind;
      logic                               line_end;
      logic [COEF_INDEX_BITS-1:0]         coef_index;
      logic signed [COEF_BITS-1:0]        coef_value;
      logic signed [SAMPLE_MAX_BITS-1:0]  sample;
   } queue_entry_type;

   typedef struct packed {
      logic [HALF_BITS-1:0] half_length;
      logic                 symmetric_mode;
   } config_type;

endpackage

/* sv/symmetric_fir_line_filter.sv */
`timescale 1ns / 1ps

// Line filter with a (2H+1)-tap symmetric or antisymmetric kernel and mirrored borders.
// Request beats carry either a pixel sample or a coefficient write (req_operation).
// A pixel beat with req_line_end closes the line and flushes its last H outputs.
// Each result beat carries the filtered pixel, a clip flag, line_done on the last
// pixel of a line, run_last on the last result of a request beat, and short_line
// when the line was shorter than H+1 pixels (those results are zero).
// Registers half_length (index 0) and symmetric_mode (index 1) are for the user to
// write on the csr channel while the block is idle; the block does not enforce this.
// csr_ready is always high. A four-entry queue takes request beats while the back
// end works. The back end runs every tap through one shared multiplier: a pixel
// with a filtered result is popped, runs its H+1 taps, then drain, round and emit,
// and each further flushed result runs its taps, drain, round and emit; a
// coefficient write or a pixel that gives no result only pops, and a short line
// emits one result per pixel. When rsp_stall is high while a result is held, the
// result register holds and the back end waits in its emit state; once the queue
// fills, req_stall rises.
// Reset clears the sample window, coefficients, line position and queue, and sets
// half_length to 1 and symmetric_mode to 1.
module symmetric_fir_line_filter #(
   parameter int LINE_MAX    = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  logic                                   req_line_end,
   input  logic [sfir_pkg::COEF_INDEX_BITS-1:0]   req_coef_index,
   input  logic signed [sfir_pkg::COEF_BITS-1:0]  req_coef_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_filtered,
   output logic                                   rsp_saturated,
   output logic                                   rsp_line_done,
   output logic                                   rsp_run_last,
   output logic                                   rsp_short_line,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sfir_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sfir_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   sfir_pkg::config_type       cfg_ff;
   sfir_pkg::queue_entry_type  push_entry;
   sfir_pkg::queue_entry_type  q_head;
   logic                       push;
   logic                       queue_full;
   logic                       q_not_empty;
   logic                       q_pop;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_length    <= sfir_pkg::HALF_BITS'(1);
         cfg_ff.symmetric_mode <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sfir_pkg::CSR_HALF_LENGTH: begin
               cfg_ff.half_length <= csr_data[sfir_pkg::HALF_BITS-1:0];
            end
            sfir_pkg::CSR_SYMMETRIC_MODE: begin
               cfg_ff.symmetric_mode <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   sfir_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_valid      (req_valid),
      .req_operation  (req_operation),
      .req_sample     (req_sample),
      .req_line_end   (req_line_end),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .queue_full     (queue_full),
      .req_stall      (req_stall),
      .push           (push),
      .push_entry     (push_entry)
   );

   sfir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (queue_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   sfir_back #(
      .LINE_MAX    (LINE_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_filtered   (rsp_filtered),
      .rsp_saturated  (rsp_saturated),
      .rsp_line_done  (rsp_line_done),
      .rsp_run_last   (rsp_run_last),
      .rsp_short_line (rsp_short_line)
   );

endmodule

/* sv/sfir_front.sv */
`timescale 1ns / 1ps

module sfir_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                          req_valid,
   input  logic                                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0]                 req_sample,
   input  logic                                          req_line_end,
   input  logic [sfir_pkg::COEF_INDEX_BITS-1:0]          req_coef_index,
   input  logic signed [sfir_pkg::COEF_BITS-1:0]         req_coef_value,
   input  logic                                          queue_full,
   output logic                                          req_stall,
   output logic                                          push,
   output sfir_pkg::queue_entry_type                     push_entry
);

   logic accept;
   logic keep;

   // A beat is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Coefficient writes beyond the kernel are dropped here and never reach the back.
   assign keep = !req_operation || (int'(req_coef_index) <= sfir_pkg::MAX_HALF);
   assign push = accept && keep;

   always_comb begin
      push_entry.kind       = req_operation ? sfir_pkg::ITEM_COEF : sfir_pkg::ITEM_PIXEL;
      push_entry.line_end   = req_line_end;
      push_entry.coef_index = req_coef_index;
      push_entry.coef_value = req_coef_value;
      push_entry.sample     = sfir_pkg::SAMPLE_MAX_BITS'(req_sample);
   end

endmodule

/* sv/sfir_queue.sv */
`timescale 1ns / 1ps

module sfir_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sfir_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output logic                       full,
   output logic                       not_empty,
   output sfir_pkg::queue_entry_type  head
);

   sfir_pkg::queue_entry_type                 slot_ff [sfir_pkg::QUEUE_DEPTH];
   logic [sfir_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sfir_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sfir_pkg::QUEUE_CNT_BITS-1:0]       count_ff, count_in;
   logic                                      do_push;
   logic                                      do_pop;

   assign full      = (count_ff == sfir_pkg::QUEUE_CNT_BITS'(sfir_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/sfir_back.sv */
`timescale 1ns / 1ps

module sfir_back #(
   parameter int LINE_MAX    = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfir_pkg::config_type           cfg,
   input  logic                           q_not_empty,
   input  sfir_pkg::queue_entry_type      q_head,
   output logic                           q_pop,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]  rsp_filtered,
   output logic                           rsp_saturated,
   output logic                           rsp_line_done,
   output logic                           rsp_run_last,
   output logic                           rsp_short_line
);

   localparam int MAX_HALF  = sfir_pkg::MAX_HALF;
   localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
   localparam int K_W       = $clog2(MAX_HALF + 1);
   localparam int D_W       = $clog2(WIN_DEPTH);
   localparam int POS_CAP   = LINE_MAX + 2 * MAX_HALF + 1;
   localparam int POS_W     = $clog2(POS_CAP + 1);
   localparam int PAIR_W    = SAMPLE_BITS + 1;
   localparam int PROD_W    = PAIR_W + sfir_pkg::COEF_BITS;
   localparam int ACC_W     = PROD_W + 6;
   localparam int RES_W     = ACC_W - sfir_pkg::FRAC_BITS;
   localparam logic signed [RES_W-1:0] RES_HI = RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RES_W-1:0] RES_LO = RES_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (sfir_pkg::FRAC_BITS - 1));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type                              state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0]          window_ff [WIN_DEPTH];
   logic signed [SAMPLE_BITS-1:0]          window_in [WIN_DEPTH];
   logic signed [sfir_pkg::COEF_BITS-1:0]  coef_ff [MAX_HALF + 1];
   logic signed [sfir_pkg::COEF_BITS-1:0]  coef_in [MAX_HALF + 1];
   logic [POS_W-1:0]                       pos_ff, pos_in;
   logic [POS_W-1:0]                       p_ff, p_in;
   logic [K_W-1:0]                         e_ff, e_in;
   logic [K_W-1:0]                         k_ff, k_in;
   logic [K_W-1:0]                         short_left_ff, short_left_in;
   logic                                   last_ff, last_in;
   logic                                   flush_ff, flush_in;
   logic                                   short_ff, short_in;
   logic signed [PROD_W-1:0]               prod_ff, prod_in;
   logic                                   prod_v_ff, prod_v_in;
   logic signed [ACC_W-1:0]                acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0]          res_ff, res_in;
   logic                                   res_sat_ff, res_sat_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]          rsp_filtered_ff, rsp_filtered_in;
   logic                                   rsp_saturated_ff, rsp_saturated_in;
   logic                                   rsp_line_done_ff, rsp_line_done_in;
   logic                                   rsp_run_last_ff, rsp_run_last_in;
   logic                                   rsp_short_line_ff, rsp_short_line_in;

   logic [K_W-1:0]                         h_eff;
   logic [D_W-1:0]                         idx_right;
   logic [D_W-1:0]                         idx_left;
   logic signed [SAMPLE_BITS-1:0]          val_right;
   logic signed [SAMPLE_BITS-1:0]          val_left;
   logic signed [PAIR_W-1:0]               pair;
   logic signed [ACC_W-1:0]                rounded;
   logic signed [RES_W-1:0]                shifted;
   logic                                   slot_free;
   logic                                   done;

   // Window delay of tap offset e+k or e-k, mirrored at both line borders.
   function automatic logic [D_W-1:0] tap_index(input logic [K_W-1:0] e,
                                                input logic [K_W-1:0] k,
                                                input logic right,
                                                input logic [POS_W-1:0] p);
      int d;
      d = right ? int'(e) - int'(k) : int'(e) + int'(k);
      if (d < 0) begin
         d = -d;
      end
      if (d > int'(p)) begin
         d = 2 * int'(p) - d;
      end
      return D_W'(d);
   endfunction

   // Half length clamped to the supported range.
   always_comb begin
      if (cfg.half_length == '0) begin
         h_eff = K_W'(1);
      end else if (int'(cfg.half_length) > MAX_HALF) begin
         h_eff = K_W'(MAX_HALF);
      end else begin
         h_eff = K_W'(cfg.half_length);
      end
   end

   // Pair of mirrored samples for the current tap.
   always_comb begin
      idx_right = tap_index(e_ff, k_ff, 1'b1, p_ff);
      idx_left  = tap_index(e_ff, k_ff, 1'b0, p_ff);
      val_right = (int'(idx_right) < WIN_DEPTH) ? window_ff[idx_right] : '0;
      val_left  = (int'(idx_left) < WIN_DEPTH) ? window_ff[idx_left] : '0;
      if (k_ff == '0) begin
         pair = PAIR_W'(val_right);
      end else if (cfg.symmetric_mode) begin
         pair = PAIR_W'(val_right) + PAIR_W'(val_left);
      end else begin
         pair = PAIR_W'(val_right) - PAIR_W'(val_left);
      end
   end

   // Round half up, drop the fraction, then clip.
   assign rounded = acc_ff + ROUND_HALF;
   assign shifted = RES_W'(rounded >>> sfir_pkg::FRAC_BITS);

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign done      = short_ff ? (short_left_ff == '0) : (!flush_ff || e_ff == '0);

   // Sequencer: take an item, run the taps through one multiplier, emit results.
   always_comb begin
      state_in          = state_ff;
      window_in         = window_ff;
      coef_in           = coef_ff;
      pos_in            = pos_ff;
      p_in              = p_ff;
      e_in              = e_ff;
      k_in              = k_ff;
      short_left_in     = short_left_ff;
      last_in           = last_ff;
      flush_in          = flush_ff;
      short_in          = short_ff;
      prod_in           = prod_ff;
      prod_v_in         = prod_v_ff;
      acc_in            = acc_ff;
      res_in            = res_ff;
      res_sat_in        = res_sat_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_filtered_in   = rsp_filtered_ff;
      rsp_saturated_in  = rsp_saturated_ff;
      rsp_line_done_in  = rsp_line_done_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_short_line_in = rsp_short_line_ff;
      q_pop             = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            prod_v_in = 1'b0;
            if (q_not_empty) begin
               q_pop = 1'b1;
               if (q_head.kind == sfir_pkg::ITEM_COEF) begin
                  coef_in[K_W'(q_head.coef_index)] = q_head.coef_value;
               end else begin
                  for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                     window_in[i] = window_ff[i - 1];
                  end
                  window_in[0] = SAMPLE_BITS'(q_head.sample);
                  p_in    = pos_ff;
                  last_in = q_head.line_end;
                  if (q_head.line_end) begin
                     pos_in = '0;
                  end else if (pos_ff < POS_W'(POS_CAP)) begin
                     pos_in = pos_ff + 1'b1;
                  end
                  if (pos_ff >= POS_W'(h_eff)) begin
                     // Centre pixel h behind is complete; at line end the flush follows.
                     e_in     = h_eff;
                     flush_in = q_head.line_end;
                     short_in = 1'b0;
                     k_in     = '0;
                     acc_in   = '0;
                     state_in = ST_MAC;
                  end else if (q_head.line_end) begin
                     // Line too short for the kernel: one blank result per pixel.
                     short_in      = 1'b1;
                     short_left_in = K_W'(pos_ff);
                     state_in      = ST_EMIT;
                  end
               end
            end
         end
         ST_MAC: begin
            prod_in   = PROD_W'(coef_ff[k_ff]) * PROD_W'(pair);
            prod_v_in = 1'b1;
            if (prod_v_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            k_in = k_ff + 1'b1;
            if (k_ff == h_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            acc_in    = acc_ff + ACC_W'(prod_ff);
            prod_v_in = 1'b0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (shifted > RES_HI) begin
               res_in     = SAMPLE_BITS'(RES_HI);
               res_sat_in = 1'b1;
            end else if (shifted < RES_LO) begin
               res_in     = SAMPLE_BITS'(RES_LO);
               res_sat_in = 1'b1;
            end else begin
               res_in     = SAMPLE_BITS'(shifted);
               res_sat_in = 1'b0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_filtered_in   = short_ff ? '0 : res_ff;
               rsp_saturated_in  = short_ff ? 1'b0 : res_sat_ff;
               rsp_short_line_in = short_ff;
               rsp_run_last_in   = done;
               rsp_line_done_in  = done && last_ff;
               if (done) begin
                  state_in = ST_IDLE;
               end else if (short_ff) begin
                  short_left_in = short_left_ff - 1'b1;
               end else begin
                  e_in     = e_ff - 1'b1;
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= '{default: '0};
         coef_ff      <= '{default: '0};
         pos_ff       <= '0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         coef_ff      <= coef_in;
         pos_ff       <= pos_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff              <= p_in;
      e_ff              <= e_in;
      k_ff              <= k_in;
      short_left_ff     <= short_left_in;
      last_ff           <= last_in;
      flush_ff          <= flush_in;
      short_ff          <= short_in;
      prod_ff           <= prod_in;
      acc_ff            <= acc_in;
      res_ff            <= res_in;
      res_sat_ff        <= res_sat_in;
      rsp_filtered_ff   <= rsp_filtered_in;
      rsp_saturated_ff  <= rsp_saturated_in;
      rsp_line_done_ff  <= rsp_line_done_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_short_line_ff <= rsp_short_line_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered   = rsp_filtered_ff;
   assign rsp_saturated  = rsp_saturated_ff;
   assign rsp_line_done  = rsp_line_done_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_short_line = rsp_short_line_ff;

endmodule

/* sv/sfir_checker.sv */
`timescale 1ns / 1ps

module sfir_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   input logic                          rsp_saturated,
   input logic                          rsp_line_done,
   input logic                          rsp_run_last,
   input logic                          rsp_short_line
);

   localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // A stalled result beat stays and keeps its pixel.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered))
      else $error("result beat changed while stalled");

   // The end of a line is always the last result of its request beat.
   a_line_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_run_last)
      else $error("line_done without run_last");

   // Short-line results are blank.
   a_short_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_line |-> rsp_filtered == '0 && !rsp_saturated)
      else $error("short-line result not blank");

   // A clipped result sits at one end of the sample range.
   a_clip_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_filtered == OUT_MAX || rsp_filtered == OUT_MIN)
      else $error("saturated result not at range limit");

   // No result beat leaves the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind symmetric_fir_line_filter sfir_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_filtered   (rsp_filtered),
   .rsp_saturated  (rsp_saturated),
   .rsp_line_done  (rsp_line_done),
   .rsp_run_last   (rsp_run_last),
   .rsp_short_line (rsp_short_line)
);
